### hw/rtl/stfl_pkg.sv
// Shared constants, control structs and the cosine table function for the stereo flanger.
// Used by stfl_lfo, stfl_mix and stereo_flanger; depends on nothing else.
package stfl_pkg;

    localparam int DELAY_DEPTH    = 2048;
    localparam int COS_TABLE_SIZE = 1024;

    localparam int ADDR_W    = $clog2(DELAY_DEPTH);
    localparam int SEEN_W    = $clog2(DELAY_DEPTH + 1);
    localparam int COS_IDX_W = $clog2(COS_TABLE_SIZE);
    localparam int COS_QTR   = COS_TABLE_SIZE / 4;
    localparam int COS_QTR_W = $clog2(COS_QTR + 1);

    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 2 * SAMPLE_W;
    localparam int DEPTH_W  = 11;
    localparam int PHASE_W  = 32;
    localparam int MIX_W    = 7;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int COS_MAG_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_PERCENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LFO_SHAPE   = 2'd3;

    localparam logic [MIX_W-1:0] MIX_RESET = 7'd50;
    localparam logic [MIX_W-1:0] MIX_FULL  = 7'd100;

    localparam logic [14:0] OSC_Q15     = 15'd31130;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Division by one hundred as a multiply by ceil(2^29/100) and a shift by 29.
    localparam int          DIV100_SHIFT = 29;
    localparam logic [22:0] DIV100_MULT  = 23'd5368710;

    typedef struct packed {
        logic stage0;
        logic stage1;
        logic stage2;
    } lfo_ctrl_t;

    typedef struct packed {
        logic capture;
        logic sum;
        logic scale;
    } mix_ctrl_t;

    // Magnitude of the Q1.15 cosine for table entry j of the first quarter turn.
    function automatic logic [COS_MAG_W-1:0] cos_mag(input int unsigned j);
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] c;
        logic [63:0] p;
        logic [63:0] q;
        t = (64'(j) << 32) / COS_TABLE_SIZE;
        x = (t * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        c = Q30_ONE;
        for (int i = 0; i < 7; i++)
        begin
            p = (x2 * c) >> 30;
            case (i)
                0:       p = p / 182;
                1:       p = p / 132;
                2:       p = p / 90;
                3:       p = p / 56;
                4:       p = p / 30;
                5:       p = p / 12;
                default: p = p / 2;
            endcase
            c = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
        end
        q = (c + 64'd16384) >> 15;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return q[COS_MAG_W-1:0];
    endfunction

endpackage

### hw/rtl/stfl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Self-contained; used for the delay line of the stereo flanger.
module stfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/stfl_lfo.sv
// Oscillator datapath: cosine table lookup or triangle, then the modulated delay in samples.
// Three register stages stepped by the sequencer; depends on stfl_pkg.
module stfl_lfo (
    input  logic                           clk,
    input  stfl_pkg::lfo_ctrl_t            ctrl,
    input  logic [stfl_pkg::PHASE_W-1:0]   phase,
    input  logic [stfl_pkg::DEPTH_W-1:0]   depth,
    input  logic                           shape,
    output logic [stfl_pkg::DEPTH_W-1:0]   delay
);
    import stfl_pkg::*;

    logic [COS_MAG_W-1:0] cos_rom [COS_QTR+1];

    for (genvar g = 0; g <= COS_QTR; g++)
    begin : g_rom
        localparam logic [COS_MAG_W-1:0] ENTRY = cos_mag(g);
        assign cos_rom[g] = ENTRY;
    end

    logic [COS_IDX_W-1:0] k;
    logic [COS_IDX_W-1:0] k_fold;
    logic [COS_IDX_W-1:0] j_full;
    logic [COS_QTR_W-1:0] j;
    logic                 neg;
    logic [COS_MAG_W-1:0] mag;
    logic signed [15:0]   c_next;
    logic signed [15:0]   c_reg;
    logic [32:0]          ph2;
    logic [33:0]          ph_back;
    logic [32:0]          t_next;
    logic [32:0]          t_reg;
    logic [25:0]          dk_next;
    logic [25:0]          dk_reg;

    logic signed [32:0]   osc_prod;
    logic signed [32:0]   w_full;
    logic [30:0]          w_next;
    logic [30:0]          w_reg;
    logic [41:0]          p_hi_next;
    logic [41:0]          p_hi_reg;
    logic [42:0]          p_lo_next;
    logic [42:0]          p_lo_reg;

    logic [41:0]          sine_prod;
    logic [58:0]          tri_sum;
    logic [DEPTH_W-1:0]   delay_next;
    logic [DEPTH_W-1:0]   delay_reg;

    always_comb
    begin
        k = phase[PHASE_W-1 -: COS_IDX_W];
        k_fold = k[COS_IDX_W-1] ? COS_IDX_W'(COS_TABLE_SIZE) - k : k;
        neg = k_fold > COS_IDX_W'(COS_QTR);
        j_full = neg ? COS_IDX_W'(COS_TABLE_SIZE / 2) - k_fold : k_fold;
        j = j_full[COS_QTR_W-1:0];
        mag = cos_rom[j];
        c_next = neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});

        ph2 = {phase, 1'b0};
        ph_back = 34'h2_0000_0000 - {1'b0, ph2};
        t_next = phase[PHASE_W-1] ? ph_back[32:0] : ph2;
        dk_next = 26'(depth) * 26'(OSC_Q15);
    end

    always_comb
    begin
        osc_prod = signed'({18'd0, OSC_Q15}) * 33'(c_reg);
        w_full = signed'(Q30_ONE[32:0]) - osc_prod;
        w_next = w_full[30:0];
        p_hi_next = 42'(dk_reg) * 42'(t_reg[32:17]);
        p_lo_next = 43'(dk_reg) * 43'(t_reg[16:0]);
    end

    always_comb
    begin
        sine_prod = 42'(depth) * 42'(w_reg);
        tri_sum = {p_hi_reg, 17'd0} + 59'(p_lo_reg);
        delay_next = shape ? tri_sum[57:47] : sine_prod[41:31];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.stage0)
        begin
            c_reg <= c_next;
            t_reg <= t_next;
            dk_reg <= dk_next;
        end
        if (ctrl.stage1)
        begin
            w_reg <= w_next;
            p_hi_reg <= p_hi_next;
            p_lo_reg <= p_lo_next;
        end
        if (ctrl.stage2)
        begin
            delay_reg <= delay_next;
        end
    end

    assign delay = delay_reg;

endmodule

### hw/rtl/stfl_mix.sv
// Dry and delayed mix for both channels, divided by one hundred and saturated.
// Two register stages after the dry capture; depends on stfl_pkg.
module stfl_mix (
    input  logic                                clk,
    input  stfl_pkg::mix_ctrl_t                 ctrl,
    input  logic signed [stfl_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [stfl_pkg::SAMPLE_W-1:0] right_in,
    input  logic [stfl_pkg::WORD_W-1:0]         stored,
    input  logic [stfl_pkg::MIX_W-1:0]          mix,
    output logic signed [stfl_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [stfl_pkg::SAMPLE_W-1:0] right_out
);
    import stfl_pkg::*;

    logic signed [SAMPLE_W-1:0] dry_reg [2];
    logic signed [SAMPLE_W-1:0] wet [2];
    logic signed [7:0]          dry_gain;
    logic signed [7:0]          wet_gain;
    logic signed [23:0]         prod_dry [2];
    logic signed [23:0]         prod_wet [2];
    logic signed [23:0]         sum_next [2];
    logic signed [23:0]         sum_reg [2];
    logic signed [23:0]         sum_abs [2];
    logic [21:0]                mag [2];
    logic [44:0]                scaled_next [2];
    logic [44:0]                scaled_reg [2];
    logic                       neg_reg [2];
    logic [SAMPLE_W-1:0]        quot [2];
    logic signed [SAMPLE_W:0]   res [2];
    logic signed [SAMPLE_W-1:0] sat [2];

    always_comb
    begin
        wet[0] = signed'(stored[SAMPLE_W-1:0]);
        wet[1] = signed'(stored[WORD_W-1:SAMPLE_W]);
        wet_gain = signed'({1'b0, mix});
        dry_gain = signed'({1'b0, MIX_FULL - mix});
        for (int i = 0; i < 2; i++)
        begin
            prod_dry[i] = 24'(dry_reg[i]) * 24'(dry_gain);
            prod_wet[i] = 24'(wet[i]) * 24'(wet_gain);
            sum_next[i] = prod_dry[i] + prod_wet[i];
            sum_abs[i] = sum_reg[i][23] ? -sum_reg[i] : sum_reg[i];
            mag[i] = sum_abs[i][21:0];
            scaled_next[i] = 45'(mag[i]) * 45'(DIV100_MULT);
            quot[i] = scaled_reg[i][DIV100_SHIFT +: SAMPLE_W];
            res[i] = neg_reg[i] ? -signed'({1'b0, quot[i]}) : signed'({1'b0, quot[i]});
            if (res[i] > 17'sd32767)
            begin
                sat[i] = 16'sh7fff;
            end
            else if (res[i] < -17'sd32768)
            begin
                sat[i] = 16'sh8000;
            end
            else
            begin
                sat[i] = res[i][SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            dry_reg[0] <= left_in;
            dry_reg[1] <= right_in;
        end
        for (int i = 0; i < 2; i++)
        begin
            if (ctrl.sum)
            begin
                sum_reg[i] <= sum_next[i];
            end
            if (ctrl.scale)
            begin
                scaled_reg[i] <= scaled_next[i];
                neg_reg[i] <= sum_reg[i][23];
            end
        end
    end

    assign left_out = sat[0];
    assign right_out = sat[1];

endmodule

### hw/rtl/stereo_flanger.sv
// Stereo flanger top level: configuration registers, sequencer, delay RAM and output register.
// Instantiates stfl_ram, stfl_lfo and stfl_mix; depends on stfl_pkg.
//
//   channel   direction   handshake               payload
//   in        to block    in_valid / in_stall     left_in, right_in
//   out       from block  out_valid / out_stall   left_out, right_out
//   cfg       to block    cfg_write               cfg_index, cfg_data
//
// Each word passes through the oscillator and delay products, the RAM read, the weighted
// sum, and the divide by one hundred and saturation, in that order.
// Reset clears the sequencer, pointers, phase and configuration; the delay RAM is not
// cleared, since the delay never reaches back past the words written since reset.
// A finished result waits in the output register, so the next word is taken meanwhile;
// the sequencer holds at its last step only while that register is occupied and out_stall is high.
module stereo_flanger (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [stfl_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [stfl_pkg::SAMPLE_W-1:0] right_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [stfl_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [stfl_pkg::SAMPLE_W-1:0] right_out,
    input  logic                                 cfg_write,
    input  logic [stfl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [stfl_pkg::CFG_W-1:0]           cfg_data
);
    import stfl_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_OSC1 = 3'd1;
    localparam logic [2:0] ST_OSC2 = 3'd2;
    localparam logic [2:0] ST_ADDR = 3'd3;
    localparam logic [2:0] ST_READ = 3'd4;
    localparam logic [2:0] ST_MIX1 = 3'd5;
    localparam logic [2:0] ST_MIX2 = 3'd6;

    localparam int CMP_W = (SEEN_W > DEPTH_W) ? SEEN_W : DEPTH_W;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [ADDR_W-1:0]   wp_reg;
    logic [SEEN_W-1:0]   seen_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [DEPTH_W-1:0]  delay_depth_reg;
    logic [PHASE_W-1:0]  phase_step_reg;
    logic [MIX_W-1:0]    mix_percent_reg;
    logic                lfo_shape_reg;
    logic                out_valid_reg;
    logic signed [SAMPLE_W-1:0] left_out_reg;
    logic signed [SAMPLE_W-1:0] right_out_reg;

    logic                accept;
    logic                load_out;
    lfo_ctrl_t           lfo_ctrl;
    mix_ctrl_t           mix_ctrl;
    logic [DEPTH_W-1:0]  delay_raw;
    logic [CMP_W-1:0]    delay_clamp;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WORD_W-1:0]   rd_data;
    logic [MIX_W-1:0]    mix_eff;
    logic signed [SAMPLE_W-1:0] left_mix;
    logic signed [SAMPLE_W-1:0] right_mix;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign load_out = (state_reg == ST_MIX2) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        lfo_ctrl.stage0 = accept;
        lfo_ctrl.stage1 = (state_reg == ST_OSC1);
        lfo_ctrl.stage2 = (state_reg == ST_OSC2);
        mix_ctrl.capture = accept;
        mix_ctrl.sum = (state_reg == ST_READ);
        mix_ctrl.scale = (state_reg == ST_MIX1);
        mix_eff = (mix_percent_reg > MIX_FULL) ? MIX_FULL : mix_percent_reg;
    end

    always_comb
    begin
        delay_clamp = CMP_W'(delay_raw);
        if (delay_clamp > CMP_W'(seen_reg))
        begin
            delay_clamp = CMP_W'(seen_reg);
        end
        if (delay_clamp > CMP_W'(DELAY_DEPTH - 1))
        begin
            delay_clamp = CMP_W'(DELAY_DEPTH - 1);
        end
        rd_addr = wp_reg - delay_clamp[ADDR_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_OSC1;
                end
            end
            ST_OSC1: state_next = ST_OSC2;
            ST_OSC2: state_next = ST_ADDR;
            ST_ADDR: state_next = ST_READ;
            ST_READ: state_next = ST_MIX1;
            ST_MIX1: state_next = ST_MIX2;
            ST_MIX2:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg <= '0;
            seen_reg <= '0;
            phase_reg <= '0;
            delay_depth_reg <= '0;
            phase_step_reg <= '0;
            mix_percent_reg <= MIX_RESET;
            lfo_shape_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ADDR)
            begin
                wp_reg <= wp_reg + ADDR_W'(1);
                if (seen_reg < SEEN_W'(DELAY_DEPTH))
                begin
                    seen_reg <= seen_reg + SEEN_W'(1);
                end
                phase_reg <= phase_reg + phase_step_reg;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_DELAY_DEPTH: delay_depth_reg <= cfg_data[DEPTH_W-1:0];
                    CFG_PHASE_STEP:  phase_step_reg <= cfg_data[PHASE_W-1:0];
                    CFG_MIX_PERCENT: mix_percent_reg <= cfg_data[MIX_W-1:0];
                    CFG_LFO_SHAPE:   lfo_shape_reg <= cfg_data[0];
                    default:         lfo_shape_reg <= lfo_shape_reg;
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            left_out_reg <= left_mix;
            right_out_reg <= right_mix;
        end
    end

    stfl_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DELAY_DEPTH)
    ) u_delay_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wp_reg),
        .wr_data ({right_in, left_in}),
        .rd_en   (state_reg == ST_ADDR),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stfl_lfo u_lfo (
        .clk   (clk),
        .ctrl  (lfo_ctrl),
        .phase (phase_reg),
        .depth (delay_depth_reg),
        .shape (lfo_shape_reg),
        .delay (delay_raw)
    );

    stfl_mix u_mix (
        .clk       (clk),
        .ctrl      (mix_ctrl),
        .left_in   (left_in),
        .right_in  (right_in),
        .stored    (rd_data),
        .mix       (mix_eff),
        .left_out  (left_mix),
        .right_out (right_mix)
    );

    assign out_valid = out_valid_reg;
    assign left_out = left_out_reg;
    assign right_out = right_out_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_OSC1)
        else $error("accepted word did not start the sequencer");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_W'(DELAY_DEPTH))
        else $error("sample count passed the delay depth");

    a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADDR |-> delay_clamp <= CMP_W'(seen_reg))
        else $error("delay reaches past the samples written");

    a_pointer_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADDR |=> wp_reg == $past(wp_reg) + ADDR_W'(1))
        else $error("write pointer did not advance once per word");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_MIX2)
        else $error("result appeared outside the final step");

endmodule
